// ----- rtl/cmr_pkg.sv -----
// ----------------------------------------------------------------------------
// cmr_pkg
// Shared widths, register indexes, mode codes and queue item type for the
// character mask rewriter.
// ----------------------------------------------------------------------------
package cmr_pkg;

	localparam int CHAR_W     = 21;
	localparam int COUNT_W    = 16;
	localparam int MASK_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int REG_RULES  = 4;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_TYPE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_CHAR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RULE_BASE   = 3'd3;

	// mode codes, six and seven pass characters through
	localparam logic [2:0] MODE_CUSTOM      = 3'd0;
	localparam logic [2:0] MODE_ALL         = 3'd1;
	localparam logic [2:0] MODE_FIRST1LAST1 = 3'd2;
	localparam logic [2:0] MODE_FIRST3LAST2 = 3'd3;
	localparam logic [2:0] MODE_FIRST3LAST4 = 3'd4;
	localparam logic [2:0] MODE_LAST4       = 3'd5;

	localparam logic [2:0]       MODE_RESET = MODE_ALL;
	localparam logic [MASK_W-1:0] MASK_RESET = 8'd42;

	typedef struct packed {
		logic [2:0] mode;
		logic       custom_type;
	} ctl_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              keep;
		logic              last;
	} item_t;

endpackage

// ----- rtl/cmr_if.sv -----
// ----------------------------------------------------------------------------
// cmr interfaces
// Valid/ready channels for characters in, characters out and register writes.
// ----------------------------------------------------------------------------
interface cmr_in_if import cmr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  char_in;
	logic [COUNT_W-1:0] char_count;
	logic               last_in;

	modport source (output valid, char_in, char_count, last_in, input ready);
	modport sink (input valid, char_in, char_count, last_in, output ready);
endinterface

interface cmr_out_if import cmr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_out;
	logic              last_out;

	modport source (output valid, char_out, last_out, input ready);
	modport sink (input valid, char_out, last_out, output ready);
endinterface

interface cmr_cfg_if import cmr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/character_mask_rewriter.sv -----
// ----------------------------------------------------------------------------
// character_mask_rewriter
// Passes decoded characters through or replaces them with a mask character,
// by fixed head/tail modes or by up to four configurable position ranges.
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                          transfer when
//  src      in   char_in, char_count, last_in    src.valid && src.ready
//  dst      out  char_out, last_out              dst.valid && dst.ready
//  cfg      in   index, data                     cfg.valid (ready tied high)
//
// one character per cycle sustained while dst is ready; a character transferred on src
// is written into the queue and then into the output register before it can leave on dst
// the front decides keep/mask in the cycle of the transfer, a two-entry queue
// and the output register let dst stall for up to three items before src stalls
// arst_n clears the position counter, queue, output valid and all registers to
// mode mask-all, mask '*', custom ranges off
//
module character_mask_rewriter import cmr_pkg::*; #(
	parameter int NUM_RULES = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	cmr_in_if.sink  src,
	cmr_out_if.source dst,
	cmr_cfg_if.sink cfg
);

	// ranges past the register set never match, so they get no storage
	localparam int NumLive = (NUM_RULES < REG_RULES) ? NUM_RULES : REG_RULES;
	localparam int QDepth  = 2;

	logic [2:0]            mode_q;
	logic                  custom_type_q;
	logic [MASK_W-1:0]     mask_char_q;
	logic [CFG_DATA_W-1:0] rule_q [NumLive];

	ctl_t  ctl;
	logic  push;
	item_t push_item;
	logic  q_full;
	logic  q_valid;
	item_t q_item;
	logic  pop;

	// register writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_RESET;
			custom_type_q <= 1'b0;
			mask_char_q   <= MASK_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MODE:        mode_q        <= cfg.data[2:0];
				REG_CUSTOM_TYPE: custom_type_q <= cfg.data[0];
				REG_MASK_CHAR:   mask_char_q   <= cfg.data[MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// range registers, one decode per live range
	for (genvar i = 0; i < NumLive; i++) begin : g_rule_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rule_q[i] <= '0;
			end else if (cfg.valid && (cfg.index == REG_RULE_BASE + CFG_IDX_W'(i))) begin
				rule_q[i] <= cfg.data;
			end
		end
	end

	assign ctl.mode        = mode_q;
	assign ctl.custom_type = custom_type_q;

	// front: transfer, position count and keep/mask decision
	cmr_front #(
		.N_RULES (NumLive)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.ctl    (ctl),
		.rule   (rule_q),
		.q_full (q_full),
		.push   (push),
		.item   (push_item)
	);

	// decoupling queue
	cmr_queue #(
		.WIDTH ($bits(item_t)),
		.DEPTH (QDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.rd_data   (q_item)
	);

	// back: mask substitution and output register
	cmr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.mask_char (mask_char_q),
		.pop       (pop),
		.dst       (dst)
	);

endmodule

// ----- rtl/cmr_front.sv -----
// ----------------------------------------------------------------------------
// cmr_front
// Accepts characters, tracks the position in the string and decides keep
// or mask for each one.
// ----------------------------------------------------------------------------
module cmr_front import cmr_pkg::*; #(
	parameter int N_RULES = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cmr_in_if.sink                src,
	input  ctl_t                  ctl,
	input  logic [CFG_DATA_W-1:0] rule [N_RULES],
	input  logic                  q_full,
	output logic                  push,
	output item_t                 item
);

	logic [COUNT_W-1:0] pos_q;
	logic [COUNT_W-1:0] len;
	logic [N_RULES-1:0] hit;
	logic               any_hit;
	logic               beyond;
	logic               keep;

	assign len    = src.char_count;
	assign beyond = pos_q >= len;

	// one compare pair per range, position already known below the length
	for (genvar i = 0; i < N_RULES; i++) begin : g_rule
		logic [COUNT_W-1:0] rng_start;
		logic [COUNT_W-1:0] rng_end;
		assign rng_start = rule[i][COUNT_W-1:0];
		assign rng_end   = rule[i][2*COUNT_W-1:COUNT_W];
		assign hit[i] = (rng_start != '0)
			&& (({1'b0, pos_q} + 17'd1) >= {1'b0, rng_start})
			&& (pos_q < rng_end);
	end

	assign any_hit = |hit;

	always_comb begin
		case (ctl.mode)
			MODE_CUSTOM: begin
				keep = !beyond && (ctl.custom_type ? any_hit : !any_hit);
			end
			MODE_ALL: begin
				keep = 1'b0;
			end
			MODE_FIRST1LAST1: begin
				keep = !beyond && (len >= 16'd2)
					&& ((pos_q == '0) || ((len >= 16'd3) && (pos_q == len - 16'd1)));
			end
			MODE_FIRST3LAST2: begin
				keep = !beyond && (len >= 16'd4)
					&& ((pos_q < 16'd3) || ((len >= 16'd6) && (pos_q >= len - 16'd2)));
			end
			MODE_FIRST3LAST4: begin
				keep = !beyond && (len >= 16'd4)
					&& ((pos_q < 16'd3) || ((len >= 16'd8) && (pos_q >= len - 16'd4)));
			end
			MODE_LAST4: begin
				keep = !beyond && (len >= 16'd5) && (pos_q >= len - 16'd4);
			end
			default: begin
				keep = 1'b1;
			end
		endcase
	end

	assign src.ready = !q_full;
	assign push      = src.valid && !q_full;
	assign item.ch   = src.char_in;
	assign item.keep = keep;
	assign item.last = src.last_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (src.last_in) begin
				pos_q <= '0;
			end else if (pos_q != '1) begin
				pos_q <= pos_q + 16'd1;
			end
		end
	end

	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		push && src.last_in |=> pos_q == '0)
		else $error("position not cleared after last character");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !src.last_in && (pos_q != '1) |=> pos_q == $past(pos_q) + 16'd1)
		else $error("position did not advance");

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!push |=> $stable(pos_q))
		else $error("position moved without a transfer");

endmodule

// ----- rtl/cmr_queue.sv -----
// ----------------------------------------------------------------------------
// cmr_queue
// Short register queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
module cmr_queue #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = count_q == CntW'(DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("queue count past depth");

endmodule

// ----- rtl/cmr_back.sv -----
// ----------------------------------------------------------------------------
// cmr_back
// Applies the keep/mask decision and holds the result in the output register.
// ----------------------------------------------------------------------------
module cmr_back import cmr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  item_t             q_item,
	input  logic [MASK_W-1:0] mask_char,
	output logic              pop,
	cmr_out_if.source         dst
);

	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	assign pop = q_valid && (!valid_q || dst.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (dst.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			char_q <= q_item.keep ? q_item.ch : CHAR_W'(mask_char);
			last_q <= q_item.last;
		end
	end

	assign dst.valid    = valid_q;
	assign dst.char_out = char_q;
	assign dst.last_out = last_q;

	a_mask_applied: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !q_item.keep |=> char_q == CHAR_W'(mask_char))
		else $error("masked character not replaced");

endmodule

// ----- dv/character_mask_rewriter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// character_mask_rewriter_tb
// Drives strings of decoded characters through the rewriter under random
// valid/ready gaps, predicts every output character from a local copy of the
// mode, mask and range registers plus the position counter, and compares the
// output stream in order. A directed table comes first, then register phases
// with random strings, then a short string at the largest count.
// ----------------------------------------------------------------------------
module character_mask_rewriter_tb;
	import cmr_pkg::*;

	// mode codes the package leaves unnamed, both pass characters through
	localparam logic [2:0] MODE_PASS6 = 3'd6;
	localparam logic [2:0] MODE_PASS7 = 3'd7;
	// index past the register list, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam int CHAR_MAX    = 1114111;
	localparam int IDLE_PCT    = 34;
	localparam int HOLD_CYCLES = 40;
	localparam int PHASES      = 16;
	localparam int PHASE_ITEMS = 64;
	localparam int TAIL_RUN    = 12;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SCRIPT_LEN  = 34;

	typedef enum logic {ROW_WRITE, ROW_CHAR} row_kind_t;

	// one directed row: a register write or a character, with an optional
	// hand-typed output character
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [CHAR_W-1:0]     ch;
		logic [COUNT_W-1:0]    count;
		logic                  last;
		logic                  typed;
		logic [CHAR_W-1:0]     typed_ch;
	} step_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cmr_in_if  src_if();
	cmr_out_if dst_if();
	cmr_cfg_if cfg_if();

	character_mask_rewriter #(
		.NUM_RULES(4)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.src(src_if),
		.dst(dst_if),
		.cfg(cfg_if)
	);

	// local copy of the register file and the position counter
	logic [2:0]            mode_q = MODE_RESET;
	logic                  ctype_q = 1'b0;
	logic [MASK_W-1:0]     mask_q = MASK_RESET;
	logic [CFG_DATA_W-1:0] rule_q [REG_RULES] = '{default: '0};
	logic [COUNT_W-1:0]    position_q = '0;

	// output characters still owed by the block, oldest first
	char_res_t pending_out [$];
	char_res_t seen_want;

	int  mismatches = 0;
	int  cycle_count = 0;
	logic no_idle = 1'b0;
	logic hold_req = 1'b0;
	int  hold_left = 0;

	// directed table: reset state, every named mode, an unused mode code, the zero
	// count, the largest count, a range with start past its end and a write past the list
	step_t script [SCRIPT_LEN] = '{
		// after reset every character becomes an asterisk
		'{ROW_CHAR, '0, '0, 21'h10FFFF, 16'd3, 1'b0, 1'b1, 21'd42},
		'{ROW_CHAR, '0, '0, 21'h000000, 16'd3, 1'b0, 1'b1, 21'd42},
		'{ROW_CHAR, '0, '0, 21'h0F0041, 16'd3, 1'b1, 1'b1, 21'd42},
		// unused mode code passes the character even with a zero count
		'{ROW_WRITE, REG_MODE, 32'(MODE_PASS7), '0, '0, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h10FFFF, 16'd0, 1'b1, 1'b1, 21'h10FFFF},
		// keep first and last, all-ones mask
		'{ROW_WRITE, REG_MODE, 32'(MODE_FIRST1LAST1), '0, '0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_MASK_CHAR, 32'hFF, '0, '0, 1'b0, 1'b0, '0},
		// zero count masks even the head
		'{ROW_CHAR, '0, '0, 21'h61, 16'd0, 1'b1, 1'b1, 21'hFF},
		'{ROW_CHAR, '0, '0, 21'h61, 16'd3, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h62, 16'd3, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h63, 16'd3, 1'b1, 1'b0, '0},
		// head of three, tail of two needs six characters
		'{ROW_WRITE, REG_MODE, 32'(MODE_FIRST3LAST2), '0, '0, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h64, 16'd4, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h65, 16'd4, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h66, 16'd4, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h67, 16'd4, 1'b1, 1'b0, '0},
		// head of three, tail of four: two characters are too short
		'{ROW_WRITE, REG_MODE, 32'(MODE_FIRST3LAST4), '0, '0, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h71, 16'd2, 1'b0, 1'b1, 21'hFF},
		'{ROW_CHAR, '0, '0, 21'h72, 16'd2, 1'b1, 1'b1, 21'hFF},
		// tail of four at the largest count, zero mask
		'{ROW_WRITE, REG_MODE, 32'(MODE_LAST4), '0, '0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_MASK_CHAR, 32'h0, '0, '0, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h10FFFF, 16'hFFFF, 1'b0, 1'b1, 21'h0},
		'{ROW_CHAR, '0, '0, 21'h000001, 16'hFFFF, 1'b1, 1'b1, 21'h0},
		// custom ranges masked: second character only
		'{ROW_WRITE, REG_MODE, 32'(MODE_CUSTOM), '0, '0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_RULE_BASE, 32'h0002_0002, '0, '0, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h41, 16'd3, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h42, 16'd3, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h43, 16'd3, 1'b1, 1'b0, '0},
		// custom ranges kept; start past end covers nothing
		'{ROW_WRITE, REG_CUSTOM_TYPE, 32'h1, '0, '0, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_RULE_BASE + 3'd1, 32'h0001_0005, '0, '0, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h44, 16'd2, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h45, 16'd2, 1'b1, 1'b0, '0},
		// write past the register list changes nothing
		'{ROW_WRITE, REG_UNUSED, 32'hFFFF_FFFF, '0, '0, 1'b0, 1'b0, '0},
		'{ROW_CHAR, '0, '0, 21'h46, 16'd1, 1'b1, 1'b0, '0}
	};

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// position p (zero-based) inside the union of enabled ranges,
	// each range end clamped to the count
	function automatic logic in_rule_ranges(int p, int n);
		int first;
		int stop;
		int lim;
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < REG_RULES; i++) begin
			first = int'(rule_q[i][15:0]);
			stop = int'(rule_q[i][31:16]);
			lim = (stop < n) ? stop : n;
			if (first != 0 && p >= first - 1 && p < lim)
				hit = 1'b1;
		end
		return hit;
	endfunction

	// keep decision for a position already known to lie below the count
	function automatic logic keeps_position(int p, int n);
		case (mode_q)
		MODE_CUSTOM:      return ctype_q ? in_rule_ranges(p, n) : !in_rule_ranges(p, n);
		MODE_ALL:         return 1'b0;
		MODE_FIRST1LAST1: return n > 1 && (p == 0 || (n >= 3 && p == n - 1));
		MODE_FIRST3LAST2: return n > 3 && (p < 3 || (n >= 6 && p >= n - 2));
		MODE_FIRST3LAST4: return n > 3 && (p < 3 || (n >= 8 && p >= n - 4));
		MODE_LAST4:       return n > 4 && p >= n - 4;
		default:          return 1'b1;
		endcase
	endfunction

	// output character for one accepted input; advances the position
	function automatic char_res_t rewrite_char(logic [CHAR_W-1:0] ch,
			logic [COUNT_W-1:0] count, logic last);
		char_res_t res;
		logic keep;
		if (mode_q == MODE_PASS6 || mode_q == MODE_PASS7)
			keep = 1'b1;
		else if (position_q >= count)
			keep = 1'b0;
		else
			keep = keeps_position(int'(position_q), int'(count));
		res.ch = keep ? ch : CHAR_W'(mask_q);
		res.last = last;
		if (last)
			position_q = '0;
		else if (position_q != '1)
			position_q = position_q + 1'b1;
		return res;
	endfunction

	// register write, called at a falling edge with nothing in flight
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = data;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
		REG_MODE:        mode_q = data[2:0];
		REG_CUSTOM_TYPE: ctype_q = data[0];
		REG_MASK_CHAR:   mask_q = data[MASK_W-1:0];
		default: begin
			if (idx >= REG_RULE_BASE && idx < REG_RULE_BASE + REG_RULES)
				rule_q[idx - REG_RULE_BASE] = data;
		end
		endcase
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// offer one character after a random gap; valid stays up after the
	// transfer so back-to-back items need no drop in between
	task automatic send_char(logic [CHAR_W-1:0] ch, logic [COUNT_W-1:0] count,
			logic last, logic typed, logic [CHAR_W-1:0] typed_ch);
		char_res_t res;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			src_if.valid = 1'b0;
			@(negedge clk);
		end
		src_if.valid = 1'b1;
		src_if.char_in = ch;
		src_if.char_count = count;
		src_if.last_in = last;
		do @(posedge clk); while (!src_if.ready);
		res = rewrite_char(ch, count, last);
		if (typed)
			res.ch = typed_ch;
		pending_out = {pending_out, res};
		@(negedge clk);
	endtask

	// n characters with the given count field, last on the final one if closed
	task automatic send_string(int n, logic [COUNT_W-1:0] count, logic closed);
		logic [CHAR_W-1:0] ch;
		int k;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(3))
			0:       ch = CHAR_W'($urandom_range(126, 32));
			1, 2:    ch = CHAR_W'($urandom_range(CHAR_MAX));
			default: ch = $urandom_range(1) ? CHAR_W'(CHAR_MAX) : '0;
			endcase
			send_char(ch, count, closed && k == n - 1, 1'b0, '0);
		end
	endtask

	// sender pauses until every owed character has come back
	task automatic wait_idle();
		src_if.valid = 1'b0;
		while (pending_out.size() != 0)
			@(negedge clk);
	endtask

	// receiver: random ready, a no-idle stretch, and one long hold-off
	// counted here while the sender keeps offering
	initial begin
		dst_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				dst_if.ready = 1'b0;
				hold_left--;
			end else if (hold_req) begin
				dst_if.ready = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				hold_req = 1'b0;
			end else begin
				dst_if.ready = no_idle || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	// output check against the oldest owed character
	always @(posedge clk) begin
		if (arst_n && dst_if.valid && dst_if.ready) begin
			if (pending_out.size() == 0) begin
				$display("%0t: unexpected transfer char %h last %b, none owed",
					$time, dst_if.char_out, dst_if.last_out);
				mismatches++;
			end else begin
				seen_want = pending_out.pop_front();
				if (dst_if.char_out !== seen_want.ch) begin
					$display("%0t: char_out expected %h actual %h",
						$time, seen_want.ch, dst_if.char_out);
					mismatches++;
				end
				if (dst_if.last_out !== seen_want.last) begin
					$display("%0t: last_out expected %b actual %b",
						$time, seen_want.last, dst_if.last_out);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("character_mask_rewriter verification failed");
			$finish;
		end
	end

	initial begin
		int k;
		int ph;
		int ri;
		int n;
		int sel;
		int done;
		logic hold_sent;
		logic [2:0] md;
		logic [COUNT_W-1:0] c;
		logic [CFG_DATA_W-1:0] w;

		hold_sent = 1'b0;
		src_if.valid = 1'b0;
		src_if.char_in = '0;
		src_if.char_count = '0;
		src_if.last_in = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;

		// reset held low from time zero, released on a falling edge
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (k = 0; k < SCRIPT_LEN; k++) begin
			if (script[k].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(script[k].idx, script[k].data);
			end else begin
				send_char(script[k].ch, script[k].count, script[k].last,
					script[k].typed, script[k].typed_ch);
			end
		end

		// register phases with random strings; the first eight walk every
		// mode code, mask extremes in phases one and two
		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			no_idle = (ph == 10 || ph == 11);

			if (ph < 8)
				md = 3'(ph);
			else if (ph % 3 == 0)
				md = MODE_CUSTOM;
			else
				md = 3'($urandom_range(7));
			// upper data bits are random, only the low bits matter
			w = $urandom();
			w[2:0] = md;
			write_reg(REG_MODE, w);

			w = $urandom();
			if (ph == 0)
				w[0] = 1'b0;
			else if (ph == 8)
				w[0] = 1'b1;
			write_reg(REG_CUSTOM_TYPE, w);

			w = $urandom();
			if (ph == 1)
				w[7:0] = 8'h00;
			else if (ph == 2)
				w[7:0] = 8'hFF;
			write_reg(REG_MASK_CHAR, w);

			// ranges: mostly short windows near the head, some off, some
			// random words, some all ones
			for (ri = 0; ri < REG_RULES; ri++) begin
				case ($urandom_range(9))
				0:       w = '0;
				1:       w = $urandom();
				2:       w = '1;
				default: w = {16'($urandom_range(16)), 16'($urandom_range(12, 1))};
				endcase
				write_reg(REG_RULE_BASE + 3'(ri), w);
			end
			if ($urandom_range(3) == 0)
				write_reg(REG_UNUSED, $urandom());

			done = 0;
			while (done < PHASE_ITEMS) begin
				// one long receiver hold-off while the sender keeps going
				if (ph == 5 && done >= 20 && !hold_sent) begin
					hold_req = 1'b1;
					hold_sent = 1'b1;
				end
				sel = $urandom_range(99);
				if (sel < 60)
					n = $urandom_range(8, 1);
				else if (sel < 85)
					n = $urandom_range(24, 9);
				else
					n = $urandom_range(40, 1);
				// mostly a matching count, the rest inconsistent counts
				if ($urandom_range(9) < 8) begin
					c = 16'(n);
				end else begin
					case ($urandom_range(3))
					0:       c = '0;
					1:       c = 16'($urandom());
					2:       c = 16'(n - 1);
					default: c = 16'(n + $urandom_range(3, 1));
					endcase
				end
				// now and then a string runs on without its last mark
				send_string(n, c, $urandom_range(19) != 0);
				done += n;
			end
		end

		// a short string at the largest count, then a short one to show
		// the position starts over
		wait_idle();
		no_idle = 1'b0;
		write_reg(REG_MODE, 32'(MODE_LAST4));
		send_string(TAIL_RUN, 16'hFFFF, 1'b1);
		send_string(3, 16'd3, 1'b1);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("character_mask_rewriter verification clean");
		else
			$display("character_mask_rewriter verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/cmr_pkg.sv
rtl/cmr_if.sv
rtl/cmr_front.sv
rtl/cmr_queue.sv
rtl/cmr_back.sv
rtl/character_mask_rewriter.sv
dv/character_mask_rewriter_tb.sv
